/* design/order_flow_window_stats_assert.svh */
// Assertion macros for the order flow window statistics block.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ORDER_FLOW_WINDOW_STATS_ASSERT_SVH
`define ORDER_FLOW_WINDOW_STATS_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OFWS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OFWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ofws_pkg.sv */
// Shared codes and types for the order flow window statistics block.
// No dependencies; imported by order_flow_window_stats.
package ofws_pkg;

  typedef logic [1:0] func_code_t;
  typedef logic [1:0] reg_idx_t;
  typedef logic [4:0] metric_id_t;

  localparam func_code_t FUNC_TRADE  = 2'd0;
  localparam func_code_t FUNC_QUOTE  = 2'd1;
  localparam func_code_t FUNC_FINISH = 2'd2;

  localparam logic [1:0] SIDE_BUY  = 2'd0;
  localparam logic [1:0] SIDE_SELL = 2'd1;

  localparam reg_idx_t REG_WINDOW_START = 2'd0;
  localparam reg_idx_t REG_WINDOW_END   = 2'd1;

  localparam metric_id_t M_TRADES     = 5'd0;
  localparam metric_id_t M_BUY        = 5'd1;
  localparam metric_id_t M_SELL       = 5'd2;
  localparam metric_id_t M_UNKNOWN    = 5'd3;
  localparam metric_id_t M_DELTA      = 5'd4;
  localparam metric_id_t M_DELTA_PCT  = 5'd5;
  localparam metric_id_t M_CLASS_PCT  = 5'd6;
  localparam metric_id_t M_QTEST_PCT  = 5'd7;
  localparam metric_id_t M_IMB_AVG    = 5'd8;
  localparam metric_id_t M_SPREAD_AVG = 5'd9;
  localparam metric_id_t M_SKEW       = 5'd10;
  localparam metric_id_t M_OFI        = 5'd11;
  localparam metric_id_t M_OFI_PCT    = 5'd12;
  localparam metric_id_t M_TP_FIRST   = 5'd13;
  localparam metric_id_t M_TP_LAST    = 5'd14;
  localparam metric_id_t M_MID_FIRST  = 5'd15;
  localparam metric_id_t M_MID_LAST   = 5'd16;
  localparam metric_id_t M_PX_CHANGE  = 5'd17;
  localparam metric_id_t M_IMPACT     = 5'd18;
  localparam metric_id_t M_QUOTES     = 5'd19;
  localparam metric_id_t M_COMPLETE   = 5'd20;

  localparam int SCALE_PCT    = 100;
  localparam int SCALE_BP     = 10000;
  localparam int SCALE_SPREAD = 20000;

  localparam logic [63:0] VMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] TALLY_MAX = 32'hFFFF_FFFF;

endpackage

/* design/order_flow_window_stats.sv */
// Order flow statistics over one time window with level-1 order flow imbalance.
// Depends on ofws_pkg and order_flow_window_stats_assert.svh.
//
// Usage: window_start and window_end are written over the cfg channel while
// the block is idle; cfg_ready is always high. Items enter on the in channel
// (trade, quote or finish). A valid quote inside the window runs three ratio
// jobs on one shared shift-add multiplier and one radix-2 divider: each job
// multiplies its two numerator operands and the scale constant, multiplies
// its two denominator operands and then divides bit by bit. A finish item
// runs eight ratio jobs and then sends 21 metric items on the out channel,
// each loaded into the output register and held until the receiver takes
// it; the statistics clear when the last metric is taken. in_ready is low
// for the whole time an item is worked on.
// A stalled receiver simply holds the current metric in the output register.
// Reset clears all statistics, sets the window to its full range and leaves
// the block idle.
module order_flow_window_stats #(
  parameter int PRICE_BITS = 32,
  parameter int SIZE_BITS  = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  ofws_pkg::reg_idx_t         cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ofws_pkg::func_code_t       in_func,
  input  logic [31:0]                in_event_time,
  input  logic [PRICE_BITS-1:0]      in_trade_price,
  input  logic [SIZE_BITS-1:0]       in_trade_size,
  input  logic [1:0]                 in_trade_side,
  input  logic                       in_by_quote_test,
  input  logic [PRICE_BITS-1:0]      in_bid_price,
  input  logic [PRICE_BITS-1:0]      in_ask_price,
  input  logic [SIZE_BITS-1:0]       in_bid_size,
  input  logic [SIZE_BITS-1:0]       in_ask_size,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ofws_pkg::metric_id_t       out_metric_id,
  output logic signed [63:0]         out_metric_value,
  output logic                       out_metric_present,
  output logic                       out_last_metric
);
  import ofws_pkg::*;

  localparam int P    = PRICE_BITS;
  localparam int S    = SIZE_BITS;
  localparam int F    = FRAC_BITS;
  localparam int NUMW = ((P + S + 14 > 71) ? P + S + 14 : 71) + F + 1;
  localparam int DW   = (P + S + 2 > 65) ? P + S + 2 : 65;
  localparam int MX   = (P > S) ? P : S;
  localparam int BW   = ((MX > 14) ? MX : 14) + 1;
  localparam int EW   = S + 2;
  localparam logic signed [63:0] LIM = 64'(SCALE_PCT) << F;

  typedef enum logic [3:0] {
    S_IDLE, S_EVT, S_LOAD, S_MUL1, S_MUL2, S_MULD, S_DCHK, S_DIV, S_COMMIT, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    T_IMB, T_SKEW, T_SPR, T_DR, T_COV, T_QTC, T_IMBA, T_SPRA, T_OFR, T_PC, T_EFF
  } task_t;

  function automatic logic [63:0] add_cap(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, VMAX}) ? VMAX : s[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? $signed(~VMAX) : $signed(VMAX);
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  state_t state_r;
  task_t  task_r;

  logic [31:0] ws_r, we_r;
  logic [31:0] trades_r, quotes_r;
  logic [63:0] buy_r, sell_r, unk_r, qtv_r, act_r;
  logic signed [63:0] imb_r, spr_r, ofi_r, skew_r;
  logic skew_p_r;
  logic [P-1:0] pq_bid_r, pq_ask_r;
  logic [S-1:0] pq_bs_r, pq_as_r;
  logic pq_p_r;
  logic [P-1:0] tp_first_r, tp_last_r;
  logic tp_seen_r;
  logic [P:0] mid_first_r, mid_last_r;
  logic mid_seen_r;
  logic [1:0] hist_r;

  func_code_t ev_func_r;
  logic [31:0] ev_time_r;
  logic [P-1:0] ev_price_r, ev_bid_r, ev_ask_r;
  logic [S-1:0] ev_size_r, ev_bs_r, ev_as_r;
  logic [1:0] ev_side_r;
  logic ev_qt_r;

  logic signed [63:0] dr_r, cov_r, qtc_r, imba_r, spra_r, ofr_r, pc_r, eff_r;

  logic [NUMW-1:0] mul_a_r, acc_r, num_r;
  logic [BW-1:0] mul_b_r;
  logic [DW-1:0] den_r, rem_r;
  logic [63:0] quo_r;
  logic [5:0] cnt_r;
  logic sat_r;

  logic out_valid_r, out_pres_r, out_last_r;
  metric_id_t out_id_r;
  logic signed [63:0] out_val_r;

  // Event decode.
  logic in_win, tr_in, q_valid;
  logic [S-1:0] sd;
  logic [S:0] disp;
  logic [P:0] qsum;
  logic [P-1:0] qspr;
  assign in_win  = (ev_time_r >= ws_r) && (ev_time_r <= we_r);
  assign tr_in   = in_win && (ev_size_r != '0);
  assign q_valid = (ev_bid_r != '0) && (ev_ask_r >= ev_bid_r);
  assign sd      = (ev_bs_r >= ev_as_r) ? ev_bs_r - ev_as_r : ev_as_r - ev_bs_r;
  assign disp    = {1'b0, ev_bs_r} + {1'b0, ev_as_r};
  assign qsum    = {1'b0, ev_bid_r} + {1'b0, ev_ask_r};
  assign qspr    = ev_ask_r - ev_bid_r;

  // Level-1 order flow contribution against the prior quote.
  logic signed [EW-1:0] bs_s, as_s, pbs_s, pas_s, be, ae, be_m, ae_m;
  logic signed [EW:0] bae;
  logic [63:0] act_nxt;
  logic signed [63:0] ofi_nxt;
  always_comb begin
    bs_s  = $signed({2'b00, ev_bs_r});
    as_s  = $signed({2'b00, ev_as_r});
    pbs_s = $signed({2'b00, pq_bs_r});
    pas_s = $signed({2'b00, pq_as_r});
    if (ev_bid_r > pq_bid_r) begin
      be = bs_s;
    end else if (ev_bid_r < pq_bid_r) begin
      be = -pbs_s;
    end else begin
      be = bs_s - pbs_s;
    end
    if (ev_ask_r > pq_ask_r) begin
      ae = pas_s;
    end else if (ev_ask_r < pq_ask_r) begin
      ae = -as_s;
    end else begin
      ae = pas_s - as_s;
    end
    bae     = (EW + 1)'(be) + (EW + 1)'(ae);
    be_m    = be[EW-1] ? -be : be;
    ae_m    = ae[EW-1] ? -ae : ae;
    ofi_nxt = add_sat(ofi_r, 64'(bae));
    act_nxt = add_cap(act_r, 64'($unsigned(be_m)) + 64'($unsigned(ae_m)));
  end

  // Report-time conditions.
  logic [63:0] cls;
  logic [64:0] tot;
  logic dr_ok, tot_nz, q_nz, act_nz, tp_ok, mid_ok, pc_ok, eff_ok;
  logic [P-1:0] tp_diff;
  logic [P:0] mid_diff;
  assign cls      = buy_r + sell_r;
  assign tot      = {1'b0, cls} + {1'b0, unk_r};
  assign dr_ok    = cls != '0;
  assign tot_nz   = tot != '0;
  assign q_nz     = quotes_r != '0;
  assign act_nz   = act_r != '0;
  assign tp_ok    = tp_seen_r && (tp_first_r != '0);
  assign mid_ok   = mid_seen_r && (mid_first_r != '0);
  assign pc_ok    = tp_ok || mid_ok;
  assign eff_ok   = pc_ok && dr_ok && (dr_r != '0);
  assign tp_diff  = (tp_last_r >= tp_first_r) ? tp_last_r - tp_first_r
                                              : tp_first_r - tp_last_r;
  assign mid_diff = (mid_last_r >= mid_first_r) ? mid_last_r - mid_first_r
                                                : mid_first_r - mid_last_r;

  // Operands of the current ratio job: (t_a * t_b * t_k [<< F]) / (t_da * t_db).
  logic [NUMW-1:0] t_a, t_da;
  logic [BW-1:0] t_b, t_k, t_db;
  logic t_sh, t_neg;
  always_comb begin
    t_a   = '0;
    t_b   = BW'(1);
    t_k   = BW'(1);
    t_da  = '0;
    t_db  = BW'(1);
    t_sh  = 1'b1;
    t_neg = 1'b0;
    unique case (task_r)
      T_IMB: begin
        t_a   = NUMW'(sd);
        t_k   = BW'(SCALE_PCT);
        t_da  = NUMW'(disp);
        t_neg = ev_as_r > ev_bs_r;
      end
      T_SKEW: begin
        t_a   = NUMW'(qspr);
        t_b   = BW'(sd);
        t_k   = BW'(SCALE_BP);
        t_da  = NUMW'(qsum);
        t_db  = BW'(disp);
        t_neg = ev_as_r > ev_bs_r;
      end
      T_SPR: begin
        t_a  = NUMW'(qspr);
        t_k  = BW'(SCALE_SPREAD);
        t_da = NUMW'(qsum);
      end
      T_DR: begin
        t_a   = NUMW'((buy_r >= sell_r) ? buy_r - sell_r : sell_r - buy_r);
        t_k   = BW'(SCALE_PCT);
        t_da  = NUMW'(cls);
        t_neg = sell_r > buy_r;
      end
      T_COV: begin
        t_a  = NUMW'(cls);
        t_k  = BW'(SCALE_PCT);
        t_da = NUMW'(tot);
      end
      T_QTC: begin
        t_a  = NUMW'(qtv_r);
        t_k  = BW'(SCALE_PCT);
        t_da = NUMW'(tot);
      end
      T_IMBA: begin
        t_a   = NUMW'(mag64(imb_r));
        t_sh  = 1'b0;
        t_da  = NUMW'(quotes_r);
        t_neg = imb_r[63];
      end
      T_SPRA: begin
        t_a   = NUMW'(mag64(spr_r));
        t_sh  = 1'b0;
        t_da  = NUMW'(quotes_r);
        t_neg = spr_r[63];
      end
      T_OFR: begin
        t_a   = NUMW'(mag64(ofi_r));
        t_k   = BW'(SCALE_PCT);
        t_da  = NUMW'(act_r);
        t_neg = ofi_r[63];
      end
      T_PC: begin
        t_k = BW'(SCALE_BP);
        if (tp_ok) begin
          t_a   = NUMW'(tp_diff);
          t_da  = NUMW'(tp_first_r);
          t_neg = tp_last_r < tp_first_r;
        end else begin
          t_a   = NUMW'(mid_diff);
          t_da  = NUMW'(mid_first_r);
          t_neg = mid_last_r < mid_first_r;
        end
      end
      T_EFF: begin
        t_a   = NUMW'(mag64(pc_r));
        t_da  = NUMW'(mag64(dr_r));
        t_neg = pc_r[63];
      end
      default: begin
        t_a = '0;
      end
    endcase
  end

  // Shared shift-add multiplier and restoring divider datapath.
  logic [NUMW-1:0] acc_nxt;
  logic [63:0] num_lo;
  logic [DW:0] trial;
  logic div_ge, div_sat, rnd;
  logic [DW-1:0] rem_nxt;
  logic [63:0] qmag;
  logic signed [63:0] res, ofr_c;
  assign acc_nxt = mul_b_r[0] ? acc_r + mul_a_r : acc_r;
  assign num_lo  = num_r[63:0];
  assign trial   = {rem_r, num_lo[cnt_r]};
  assign div_ge  = trial >= {1'b0, den_r};
  assign rem_nxt = div_ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
  assign div_sat = (num_r >> 63) >= NUMW'(den_r);
  assign rnd     = !sat_r && ({rem_r, 1'b0} >= {1'b0, den_r});
  assign qmag    = (quo_r == VMAX) ? VMAX : quo_r + 64'(rnd);
  assign res     = t_neg ? -$signed(qmag) : $signed(qmag);
  assign ofr_c   = (res > LIM) ? LIM : ((res < -LIM) ? -LIM : res);

  // Metric select for the output register.
  logic signed [63:0] mv;
  logic mp;
  always_comb begin
    mv = '0;
    mp = 1'b1;
    case (out_id_r)
      M_TRADES:     mv = 64'(trades_r);
      M_BUY:        mv = $signed(buy_r);
      M_SELL:       mv = $signed(sell_r);
      M_UNKNOWN:    mv = $signed(unk_r);
      M_DELTA:      mv = $signed(buy_r) - $signed(sell_r);
      M_DELTA_PCT:  begin mv = dr_r;   mp = dr_ok;      end
      M_CLASS_PCT:  begin mv = cov_r;  mp = tot_nz;     end
      M_QTEST_PCT:  begin mv = qtc_r;  mp = tot_nz;     end
      M_IMB_AVG:    begin mv = imba_r; mp = q_nz;       end
      M_SPREAD_AVG: begin mv = spra_r; mp = q_nz;       end
      M_SKEW:       begin mv = skew_r; mp = skew_p_r;   end
      M_OFI:        mv = ofi_r;
      M_OFI_PCT:    begin mv = ofr_r;  mp = act_nz;     end
      M_TP_FIRST:   begin mv = 64'(tp_first_r); mp = tp_ok; end
      M_TP_LAST:    begin mv = 64'(tp_last_r);  mp = tp_ok; end
      M_MID_FIRST:  begin
        mv = 64'(({1'b0, mid_first_r} + 1'b1) >> 1);
        mp = mid_seen_r;
      end
      M_MID_LAST:   begin
        mv = 64'(({1'b0, mid_last_r} + 1'b1) >> 1);
        mp = mid_seen_r;
      end
      M_PX_CHANGE:  begin mv = pc_r;  mp = pc_ok;  end
      M_IMPACT:     begin mv = eff_r; mp = eff_ok; end
      M_QUOTES:     mv = 64'(quotes_r);
      M_COMPLETE:   mv = (hist_r == 2'b11) ? 64'sd1 : 64'sd0;
      default: begin
        mv = '0;
        mp = 1'b0;
      end
    endcase
  end

  logic out_take, stats_clr;
  assign out_take  = out_valid_r && out_ready;
  assign stats_clr = !rst_n || (state_r == S_OUT && out_take && out_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      task_r      <= T_IMB;
      out_valid_r <= 1'b0;
      out_id_r    <= M_TRADES;
      ws_r        <= '0;
      we_r        <= '1;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WINDOW_START: ws_r <= cfg_data;
          REG_WINDOW_END:   we_r <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ev_func_r  <= in_func;
            ev_time_r  <= in_event_time;
            ev_price_r <= in_trade_price;
            ev_size_r  <= in_trade_size;
            ev_side_r  <= in_trade_side;
            ev_qt_r    <= in_by_quote_test;
            ev_bid_r   <= in_bid_price;
            ev_ask_r   <= in_ask_price;
            ev_bs_r    <= in_bid_size;
            ev_as_r    <= in_ask_size;
            state_r    <= S_EVT;
          end
        end
        S_EVT: begin
          case (ev_func_r)
            FUNC_TRADE: begin
              state_r <= S_IDLE;
              if (ev_time_r <= ws_r) begin
                hist_r[0] <= 1'b1;
              end
              if (tr_in) begin
                if (!tp_seen_r) begin
                  tp_first_r <= ev_price_r;
                  tp_seen_r  <= 1'b1;
                end
                tp_last_r <= ev_price_r;
                if (trades_r != TALLY_MAX) begin
                  trades_r <= trades_r + 1'b1;
                end
                if (ev_side_r == SIDE_BUY) begin
                  buy_r <= add_cap(buy_r, 64'(ev_size_r));
                end else if (ev_side_r == SIDE_SELL) begin
                  sell_r <= add_cap(sell_r, 64'(ev_size_r));
                end else begin
                  unk_r <= add_cap(unk_r, 64'(ev_size_r));
                end
                if (ev_qt_r) begin
                  qtv_r <= add_cap(qtv_r, 64'(ev_size_r));
                end
              end
            end
            FUNC_QUOTE: begin
              state_r <= (q_valid && in_win) ? S_LOAD : S_IDLE;
              if (ev_time_r <= ws_r) begin
                hist_r[1] <= 1'b1;
              end
              if (q_valid && (ev_time_r < ws_r || ev_time_r <= we_r)) begin
                pq_bid_r <= ev_bid_r;
                pq_ask_r <= ev_ask_r;
                pq_bs_r  <= ev_bs_r;
                pq_as_r  <= ev_as_r;
                pq_p_r   <= 1'b1;
              end
              if (q_valid && in_win) begin
                if (!mid_seen_r) begin
                  mid_first_r <= qsum;
                  mid_seen_r  <= 1'b1;
                end
                mid_last_r <= qsum;
                if (pq_p_r) begin
                  ofi_r <= ofi_nxt;
                  act_r <= act_nxt;
                end
                if (quotes_r != TALLY_MAX) begin
                  quotes_r <= quotes_r + 1'b1;
                end
                task_r <= T_IMB;
              end
            end
            FUNC_FINISH: begin
              task_r  <= T_DR;
              state_r <= S_LOAD;
            end
            default: begin
              state_r <= S_IDLE;
            end
          endcase
        end
        S_LOAD: begin
          acc_r   <= '0;
          mul_a_r <= t_a;
          mul_b_r <= t_b;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          if (mul_b_r == '0) begin
            mul_a_r <= acc_r;
            mul_b_r <= t_k;
            acc_r   <= '0;
            state_r <= S_MUL2;
          end else begin
            acc_r   <= acc_nxt;
            mul_a_r <= mul_a_r << 1;
            mul_b_r <= mul_b_r >> 1;
          end
        end
        S_MUL2: begin
          if (mul_b_r == '0) begin
            num_r   <= t_sh ? (acc_r << F) : acc_r;
            mul_a_r <= t_da;
            mul_b_r <= t_db;
            acc_r   <= '0;
            state_r <= S_MULD;
          end else begin
            acc_r   <= acc_nxt;
            mul_a_r <= mul_a_r << 1;
            mul_b_r <= mul_b_r >> 1;
          end
        end
        S_MULD: begin
          if (mul_b_r == '0) begin
            den_r   <= acc_r[DW-1:0];
            state_r <= S_DCHK;
          end else begin
            acc_r   <= acc_nxt;
            mul_a_r <= mul_a_r << 1;
            mul_b_r <= mul_b_r >> 1;
          end
        end
        S_DCHK: begin
          if (div_sat) begin
            quo_r   <= VMAX;
            sat_r   <= 1'b1;
            state_r <= S_COMMIT;
          end else begin
            rem_r   <= DW'(num_r >> 64);
            quo_r   <= '0;
            cnt_r   <= 6'd63;
            sat_r   <= 1'b0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[62:0], div_ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          task_r <= task_t'(task_r + 1'b1);
          unique case (task_r)
            T_IMB: begin
              state_r <= S_LOAD;
              if (disp != '0) begin
                imb_r <= add_sat(imb_r, res);
              end
            end
            T_SKEW: begin
              state_r <= S_LOAD;
              if (disp != '0) begin
                skew_r   <= res;
                skew_p_r <= 1'b1;
              end
            end
            T_SPR: begin
              spr_r   <= add_sat(spr_r, res);
              state_r <= S_IDLE;
            end
            T_DR: begin
              dr_r    <= res;
              state_r <= S_LOAD;
            end
            T_COV: begin
              cov_r   <= res;
              state_r <= S_LOAD;
            end
            T_QTC: begin
              qtc_r   <= res;
              state_r <= S_LOAD;
            end
            T_IMBA: begin
              imba_r  <= res;
              state_r <= S_LOAD;
            end
            T_SPRA: begin
              spra_r  <= res;
              state_r <= S_LOAD;
            end
            T_OFR: begin
              ofr_r   <= ofr_c;
              state_r <= S_LOAD;
            end
            T_PC: begin
              pc_r    <= res;
              state_r <= S_LOAD;
            end
            T_EFF: begin
              eff_r    <= res;
              out_id_r <= M_TRADES;
              state_r  <= S_OUT;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_val_r   <= mp ? mv : 64'sd0;
            out_pres_r  <= mp;
            out_last_r  <= out_id_r == M_COMPLETE;
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              out_id_r <= out_id_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (stats_clr) begin
      trades_r    <= '0;
      quotes_r    <= '0;
      buy_r       <= '0;
      sell_r      <= '0;
      unk_r       <= '0;
      qtv_r       <= '0;
      imb_r       <= '0;
      spr_r       <= '0;
      ofi_r       <= '0;
      act_r       <= '0;
      skew_r      <= '0;
      skew_p_r    <= 1'b0;
      pq_bid_r    <= '0;
      pq_ask_r    <= '0;
      pq_bs_r     <= '0;
      pq_as_r     <= '0;
      pq_p_r      <= 1'b0;
      tp_first_r  <= '0;
      tp_last_r   <= '0;
      tp_seen_r   <= 1'b0;
      mid_first_r <= '0;
      mid_last_r  <= '0;
      mid_seen_r  <= 1'b0;
      hist_r      <= 2'b00;
    end
  end

  assign cfg_ready          = 1'b1;
  assign in_ready           = state_r == S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_metric_id      = out_id_r;
  assign out_metric_value   = out_val_r;
  assign out_metric_present = out_pres_r;
  assign out_last_metric    = out_last_r;

`include "order_flow_window_stats_assert.svh"

  `OFWS_ASSERT_SAME(a_out_blocks_in, out_valid, !in_ready, "input open while reporting")
  `OFWS_ASSERT_SAME(a_last_is_complete, out_valid && out_last_metric,
                    out_metric_id == M_COMPLETE, "last flag on wrong metric")
  `OFWS_ASSERT_SAME(a_absent_is_zero, out_valid && !out_metric_present,
                    out_metric_value == 64'sd0, "absent metric carries a value")
  `OFWS_ASSERT_NEXT(a_idle_after_report, out_valid && out_ready && out_last_metric,
                    in_ready && !out_valid, "block not idle after report")

endmodule
